// ----- hw/rtl/fcpq_pkg.sv -----
package fcpq_pkg;

   // Field widths
   localparam int CLASS_W  = 2;
   localparam int TICKET_W = 10;
   localparam int OCC_W    = 8;
   localparam int STATUS_W = 2;

   // Request codes
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic                req_type;
      logic [CLASS_W-1:0]  entry_class;
      logic [TICKET_W-1:0] ticket_number;
   } fcpq_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CLASS_W-1:0]  served_class;
      logic [TICKET_W-1:0] served_ticket;
      logic [OCC_W-1:0]    occupancy;
   } fcpq_rsp_type;

   // One stored queue entry: class above ticket
   typedef struct packed {
      logic [CLASS_W-1:0]  entry_class;
      logic [TICKET_W-1:0] ticket_number;
   } fcpq_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_SCAN,
      ST_PLACE,
      ST_OUT
   } fcpq_state_type;

endpackage

// ----- hw/rtl/fcpq_ram.sv -----
module fcpq_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/four_class_priority_queue.sv -----
// Sequence: a remove reads the head entry and passes it through ST_POP and ST_OUT to the
//   output register; an insert moves each stored entry of lower class back one slot (one
//   per cycle, set by the single read and write port of the entry memory), then writes the
//   new one. Full, empty or insert into an empty queue go from acceptance straight to ST_OUT.
// Throughput: one transaction at a time; the next request is taken the cycle after the
//   response is loaded into the output register.
// Reset: synchronous, clears head, tail, count and handshake state; memory is not cleared.
module four_class_priority_queue #(
   parameter int QUEUE_DEPTH = 128
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  fcpq_pkg::fcpq_req_type     req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output fcpq_pkg::fcpq_rsp_type     rsp_data
);

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = $bits(fcpq_pkg::fcpq_entry_type);

   fcpq_pkg::fcpq_state_type state_ff, state_in;
   logic [IW-1:0]            head_ff, head_in;
   logic [IW-1:0]            tail_ff, tail_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [IW-1:0]            slot_ff, slot_in;
   logic [CW-1:0]            left_ff, left_in;
   fcpq_pkg::fcpq_req_type   cur_ff, cur_in;
   fcpq_pkg::fcpq_rsp_type   res_ff, res_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   fcpq_pkg::fcpq_rsp_type   rsp_data_ff, rsp_data_in;

   logic                     ram_wr_en;
   logic [IW-1:0]            ram_wr_addr;
   fcpq_pkg::fcpq_entry_type ram_wr_data;
   logic                     ram_rd_en;
   logic [IW-1:0]            ram_rd_addr;
   fcpq_pkg::fcpq_entry_type ram_rd_data;
   fcpq_pkg::fcpq_entry_type new_word;

   logic                     is_empty;
   logic                     is_full;
   logic                     shift_up;
   logic                     out_free;

   function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx);
      return (idx == IW'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] idx);
      return (idx == '0) ? IW'(QUEUE_DEPTH - 1) : idx - 1'b1;
   endfunction

   fcpq_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CW'(QUEUE_DEPTH));
   // Stored entry of lower class moves back behind the new one
   assign shift_up = (ram_rd_data.entry_class < cur_ff.entry_class);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign new_word = '{entry_class: cur_ff.entry_class, ticket_number: cur_ff.ticket_number};

   assign req_ready = (state_ff == fcpq_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fcpq_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_data.req_type == fcpq_pkg::REQ_REMOVE) begin
                  state_in = is_empty ? fcpq_pkg::ST_OUT : fcpq_pkg::ST_POP;
               end else begin
                  state_in = (is_full || is_empty) ? fcpq_pkg::ST_OUT : fcpq_pkg::ST_SCAN;
               end
            end
         end
         fcpq_pkg::ST_POP: begin
            state_in = fcpq_pkg::ST_OUT;
         end
         fcpq_pkg::ST_SCAN: begin
            if (!shift_up) begin
               state_in = fcpq_pkg::ST_OUT;
            end else if (left_ff == CW'(1)) begin
               state_in = fcpq_pkg::ST_PLACE;
            end
         end
         fcpq_pkg::ST_PLACE: begin
            state_in = fcpq_pkg::ST_OUT;
         end
         fcpq_pkg::ST_OUT: begin
            if (out_free) begin
               state_in = fcpq_pkg::ST_IDLE;
            end
         end
         default: state_in = fcpq_pkg::ST_IDLE;
      endcase
   end

   // Datapath, memory access and result
   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      slot_in      = slot_ff;
      left_in      = left_ff;
      cur_in       = cur_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = slot_ff;
      ram_wr_data  = new_word;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = ring_prev(ring_prev(slot_ff));
      unique case (state_ff)
         fcpq_pkg::ST_IDLE: begin
            if (req_valid) begin
               cur_in = req_data;
               res_in = '0;
               if (req_data.req_type == fcpq_pkg::REQ_REMOVE) begin
                  if (is_empty) begin
                     res_in.status = fcpq_pkg::STATUS_EMPTY;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = head_ff;
                  end
               end else if (is_full) begin
                  res_in.status = fcpq_pkg::STATUS_FULL;
               end else if (is_empty) begin
                  // Empty queue: write straight to the tail slot
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = tail_ff;
                  ram_wr_data = '{entry_class: req_data.entry_class,
                                  ticket_number: req_data.ticket_number};
                  tail_in     = ring_next(tail_ff);
                  count_in    = count_ff + 1'b1;
               end else begin
                  // Scan from the back, last entry first
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = ring_prev(tail_ff);
                  slot_in     = tail_ff;
                  left_in     = count_ff;
               end
            end
         end
         fcpq_pkg::ST_POP: begin
            res_in.served_class  = ram_rd_data.entry_class;
            res_in.served_ticket = ram_rd_data.ticket_number;
            head_in              = ring_next(head_ff);
            count_in             = count_ff - 1'b1;
         end
         fcpq_pkg::ST_SCAN: begin
            ram_wr_en = 1'b1;
            if (shift_up) begin
               ram_wr_data = ram_rd_data;
               slot_in     = ring_prev(slot_ff);
               left_in     = left_ff - 1'b1;
               ram_rd_en   = (left_ff != CW'(1));
            end else begin
               tail_in  = ring_next(tail_ff);
               count_in = count_ff + 1'b1;
            end
         end
         fcpq_pkg::ST_PLACE: begin
            // New entry goes to the head slot
            ram_wr_en = 1'b1;
            tail_in   = ring_next(tail_ff);
            count_in  = count_ff + 1'b1;
         end
         fcpq_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in           = res_ff;
               rsp_data_in.occupancy = fcpq_pkg::OCC_W'(count_ff);
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fcpq_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      left_ff     <= left_in;
      cur_ff      <= cur_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- hw/rtl/fcpq_checker.sv -----
module fcpq_checker #(
   parameter int QUEUE_DEPTH = 128
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input fcpq_pkg::fcpq_rsp_type rsp_data
);

   // A stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // One transaction in flight: ready drops after acceptance
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

   // Failed requests return no entry
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != fcpq_pkg::STATUS_DONE
      |-> rsp_data.served_class == '0 && rsp_data.served_ticket == '0)
      else $error("entry returned on failed request");

   // Full drop reports a full queue, empty remove an empty one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == fcpq_pkg::STATUS_FULL
      |-> rsp_data.occupancy == fcpq_pkg::OCC_W'(QUEUE_DEPTH))
      else $error("full status with wrong occupancy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == fcpq_pkg::STATUS_EMPTY
      |-> rsp_data.occupancy == '0)
      else $error("empty status with nonzero occupancy");

endmodule

bind four_class_priority_queue fcpq_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_fcpq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- verif/four_class_priority_queue_tb.sv -----
`timescale 1ns / 1ps

module four_class_priority_queue_tb;

   localparam int          QUEUE_DEPTH        = 128;
   localparam int          DIRECTED_LEN       = 21;
   localparam int unsigned RANDOM_ITEMS       = 1900;
   localparam int unsigned HOLDOFF_AT         = 400;
   localparam int unsigned RSP_HOLDOFF_CYCLES = 300;
   localparam int unsigned WATCHDOG_LIMIT     = 5000;
   localparam int unsigned END_QUIET          = 200;
   localparam int unsigned MAX_REPORTS        = 10;

   typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_kind_type;

   typedef struct packed {
      fcpq_pkg::fcpq_req_type req;
      logic                   chk;
      fcpq_pkg::fcpq_rsp_type rsp;
   } directed_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   fcpq_pkg::fcpq_req_type req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   fcpq_pkg::fcpq_rsp_type rsp_data;

   // Typed-in expectation travelling with the request payload
   logic                   req_check_en;
   fcpq_pkg::fcpq_rsp_type req_check_rsp;

   // Logical view of the queue, head first
   fcpq_pkg::fcpq_entry_type queue_model[$];
   fcpq_pkg::fcpq_rsp_type   expected_rsp_q[$];
   int unsigned              pending_rsp   = 0;

   int unsigned n_inserted    = 0;
   int unsigned n_served      = 0;
   int unsigned n_full_drops  = 0;
   int unsigned n_empty_pops  = 0;
   int unsigned peak_occ      = 0;
   int unsigned n_requests    = 0;
   int unsigned random_items  = 0;
   int unsigned fail_count    = 0;
   int unsigned idle_cycles   = 0;

   bit          sender_calm     = 1'b0;
   bit          rsp_calm        = 1'b0;
   bit          rsp_holdoff_req = 1'b0;
   int unsigned rsp_stall_left  = 0;

   fcpq_pkg::fcpq_rsp_type want;
   fcpq_pkg::fcpq_rsp_type model_rsp;

   // Directed table: empty, extremes of class and ticket, ordering, ignored fields
   directed_row_type directed_rows [DIRECTED_LEN] = '{
      '{'{fcpq_pkg::REQ_REMOVE, 2'd0, 10'd0}, 1'b1,
        '{fcpq_pkg::STATUS_EMPTY, 2'd0, 10'd0, 8'd0}},
      '{'{fcpq_pkg::REQ_REMOVE, 2'd3, 10'd1023}, 1'b1,
        '{fcpq_pkg::STATUS_EMPTY, 2'd0, 10'd0, 8'd0}},
      '{'{fcpq_pkg::REQ_INSERT, 2'd0, 10'd0}, 1'b1,
        '{fcpq_pkg::STATUS_DONE, 2'd0, 10'd0, 8'd1}},
      '{'{fcpq_pkg::REQ_INSERT, 2'd3, 10'd999}, 1'b1,
        '{fcpq_pkg::STATUS_DONE, 2'd0, 10'd0, 8'd2}},
      '{'{fcpq_pkg::REQ_INSERT, 2'd1, 10'd1023}, 1'b1,
        '{fcpq_pkg::STATUS_DONE, 2'd0, 10'd0, 8'd3}},
      '{'{fcpq_pkg::REQ_INSERT, 2'd2, 10'd512},  1'b0, '0},
      '{'{fcpq_pkg::REQ_INSERT, 2'd3, 10'd1},    1'b0, '0},
      '{'{fcpq_pkg::REQ_INSERT, 2'd0, 10'd1022}, 1'b0, '0},
      '{'{fcpq_pkg::REQ_INSERT, 2'd2, 10'd341},  1'b0, '0},
      '{'{fcpq_pkg::REQ_INSERT, 2'd1, 10'd682},  1'b0, '0},
      '{'{fcpq_pkg::REQ_REMOVE, 2'd0, 10'd0}, 1'b1,
        '{fcpq_pkg::STATUS_DONE, 2'd3, 10'd999, 8'd7}},
      '{'{fcpq_pkg::REQ_REMOVE, 2'd2, 10'd555},  1'b0, '0},
      '{'{fcpq_pkg::REQ_REMOVE, 2'd1, 10'd170},  1'b0, '0},
      '{'{fcpq_pkg::REQ_REMOVE, 2'd0, 10'd0},    1'b0, '0},
      '{'{fcpq_pkg::REQ_REMOVE, 2'd3, 10'd1023}, 1'b0, '0},
      '{'{fcpq_pkg::REQ_REMOVE, 2'd0, 10'd0},    1'b0, '0},
      '{'{fcpq_pkg::REQ_REMOVE, 2'd0, 10'd0},    1'b0, '0},
      '{'{fcpq_pkg::REQ_REMOVE, 2'd0, 10'd0},    1'b0, '0},
      '{'{fcpq_pkg::REQ_REMOVE, 2'd1, 10'd1}, 1'b1,
        '{fcpq_pkg::STATUS_EMPTY, 2'd0, 10'd0, 8'd0}},
      '{'{fcpq_pkg::REQ_INSERT, 2'd3, 10'd500}, 1'b1,
        '{fcpq_pkg::STATUS_DONE, 2'd0, 10'd0, 8'd1}},
      '{'{fcpq_pkg::REQ_REMOVE, 2'd0, 10'd0}, 1'b1,
        '{fcpq_pkg::STATUS_DONE, 2'd3, 10'd500, 8'd0}}
   };

   four_class_priority_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Queue behaviour: stable insert behind equal or higher class, pop from head
   function automatic fcpq_pkg::fcpq_rsp_type serve_request(input fcpq_pkg::fcpq_req_type r);
      fcpq_pkg::fcpq_rsp_type   rsp;
      fcpq_pkg::fcpq_entry_type e;
      int                       pos;
      rsp = '0;
      if (r.req_type == fcpq_pkg::REQ_INSERT) begin
         if (queue_model.size() >= QUEUE_DEPTH) begin
            rsp.status = fcpq_pkg::STATUS_FULL;
            n_full_drops++;
         end else begin
            pos = 0;
            while (pos < queue_model.size() && queue_model[pos].entry_class >= r.entry_class)
               pos++;
            e.entry_class   = r.entry_class;
            e.ticket_number = r.ticket_number;
            if (pos == queue_model.size())
               queue_model.push_back(e);
            else
               queue_model.insert(pos, e);
            rsp.status = fcpq_pkg::STATUS_DONE;
            n_inserted++;
         end
      end else begin
         if (queue_model.size() == 0) begin
            rsp.status = fcpq_pkg::STATUS_EMPTY;
            n_empty_pops++;
         end else begin
            e = queue_model.pop_front();
            rsp.status        = fcpq_pkg::STATUS_DONE;
            rsp.served_class  = e.entry_class;
            rsp.served_ticket = e.ticket_number;
            n_served++;
         end
      end
      rsp.occupancy = fcpq_pkg::OCC_W'(queue_model.size());
      if (queue_model.size() > peak_occ)
         peak_occ = queue_model.size();
      return rsp;
   endfunction

   // Mostly short idle stretches, now and then a long one
   function automatic int unsigned pick_idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return $urandom_range(1, 3);
      else if (r < 96)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 80);
   endfunction

   function automatic logic [fcpq_pkg::TICKET_W-1:0] rand_ticket();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 85)
         return fcpq_pkg::TICKET_W'($urandom_range(0, 999));
      else if (r < 95)
         return fcpq_pkg::TICKET_W'($urandom_range(1000, 1023));
      else if (r < 97)
         return '0;
      else
         return '1;
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("[%0t] %s", $time, msg);
   endtask

   // Scoreboard: check responses against the oldest expectation, then log new requests
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               note_failure($sformatf("response with nothing outstanding: status %0d", 
                                      rsp_data.status));
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.status !== want.status ||
                   rsp_data.served_class !== want.served_class ||
                   rsp_data.served_ticket !== want.served_ticket ||
                   rsp_data.occupancy !== want.occupancy)
                  note_failure($sformatf({"mismatch: expected status %0d class %0d ",
                     "ticket %0d occupancy %0d, got status %0d class %0d ticket %0d ",
                     "occupancy %0d"}, want.status, want.served_class, want.served_ticket,
                     want.occupancy, rsp_data.status, rsp_data.served_class,
                     rsp_data.served_ticket, rsp_data.occupancy));
            end
         end
         if (req_valid && req_ready) begin
            model_rsp = serve_request(req_data);
            expected_rsp_q.push_back(req_check_en ? req_check_rsp : model_rsp);
            n_requests++;
         end
         pending_rsp = expected_rsp_q.size();
      end
   end

   // Watchdog: too long without any transaction on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles at %0t", WATCHDOG_LIMIT, $time);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_holdoff_req) begin
            rsp_holdoff_req = 1'b0;
            rsp_stall_left  = RSP_HOLDOFF_CYCLES;
         end else if (rsp_stall_left == 0 && !rsp_calm && $urandom_range(0, 99) < 25) begin
            rsp_stall_left = pick_idle_len();
         end
         if (rsp_stall_left != 0) begin
            rsp_ready <= 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // One transaction on the request side; entered and left at a falling edge
   task automatic send_item(input fcpq_pkg::fcpq_req_type item, input logic chk,
                            input fcpq_pkg::fcpq_rsp_type chk_rsp);
      int unsigned gap;
      gap = (sender_calm || $urandom_range(0, 99) < 55) ? 0 : pick_idle_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data      <= item;
      req_check_en  <= chk;
      req_check_rsp <= chk_rsp;
      req_valid     <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      wait (pending_rsp == 0);
      @(negedge clock);
   endtask

   // Fill runs until a few inserts bounce off a full queue, drain until a few
   // removes hit an empty one; mixed runs a set length at a given insert share
   task automatic run_phase(input phase_kind_type kind, input int unsigned len,
                            input int unsigned ins_pct);
      fcpq_pkg::fcpq_req_type item;
      int unsigned            n;
      int unsigned            extra;
      int unsigned            c_lo;
      int unsigned            c_hi;
      int unsigned            r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         c_lo = 0;
         c_hi = 3;
      end else if (r < 80) begin
         c_lo = $urandom_range(0, 3);
         c_hi = c_lo;
      end else begin
         c_lo = $urandom_range(0, 2);
         c_hi = c_lo + 1;
      end
      sender_calm = ($urandom_range(0, 3) == 0);
      rsp_calm    = ($urandom_range(0, 3) == 0);
      n     = 0;
      extra = 0;
      while ((kind == PH_FILL && extra < 3) || (kind == PH_DRAIN && extra < 2) ||
             (kind == PH_MIXED && n < len)) begin
         case (kind)
            PH_FILL: begin
               item.req_type = fcpq_pkg::REQ_INSERT;
               if (queue_model.size() >= QUEUE_DEPTH)
                  extra++;
            end
            PH_DRAIN: begin
               item.req_type = fcpq_pkg::REQ_REMOVE;
               if (queue_model.size() == 0)
                  extra++;
            end
            default: begin
               item.req_type = ($urandom_range(0, 99) < ins_pct) ?
                               fcpq_pkg::REQ_INSERT : fcpq_pkg::REQ_REMOVE;
            end
         endcase
         item.entry_class   = fcpq_pkg::CLASS_W'($urandom_range(c_hi, c_lo));
         item.ticket_number = rand_ticket();
         send_item(item, 1'b0, '0);
         n++;
         random_items++;
         if (random_items == HOLDOFF_AT)
            rsp_holdoff_req = 1'b1;
      end
   endtask

   // Stimulus
   initial begin
      int unsigned r;
      req_valid     <= 1'b0;
      req_data      <= '0;
      req_check_en  <= 1'b0;
      req_check_rsp <= '0;
      reset         <= 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].req, directed_rows[i].chk, directed_rows[i].rsp);
      pause_until_drained();

      // One full cycle of the ring first, then random phases
      run_phase(PH_FILL, 0, 100);
      run_phase(PH_DRAIN, 0, 0);
      pause_until_drained();
      while (random_items < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 12)
            run_phase(PH_FILL, 0, 100);
         else if (r < 22)
            run_phase(PH_DRAIN, 0, 0);
         else if (r < 40)
            run_phase(PH_MIXED, $urandom_range(20, 150), 80);
         else if (r < 55)
            run_phase(PH_MIXED, $urandom_range(20, 150), 20);
         else
            run_phase(PH_MIXED, $urandom_range(20, 150), $urandom_range(30, 70));
         if ($urandom_range(0, 1) == 1)
            pause_until_drained();
      end

      // Let the last responses arrive, then watch for strays
      req_valid <= 1'b0;
      wait (pending_rsp == 0);
      repeat (END_QUIET) @(posedge clock);
      if (expected_rsp_q.size() != 0)
         note_failure($sformatf("%0d responses never arrived", expected_rsp_q.size()));

      $display("Covered %0d requests: %0d stored, %0d served, %0d dropped on a full queue, %0d %s",
               n_requests, n_inserted, n_served, n_full_drops, n_empty_pops,
               "removes on empty");
      $display("Peak occupancy %0d of %0d; %0d failures", peak_occ, QUEUE_DEPTH, fail_count);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/fcpq_pkg.sv
hw/rtl/fcpq_ram.sv
hw/rtl/four_class_priority_queue.sv
hw/rtl/fcpq_checker.sv
verif/four_class_priority_queue_tb.sv
